// ===== src/utf16_to_json_utf8_quoter_defines.svh =====
// Assertion macros shared by the quoter RTL files.
// No dependencies; the files that check their own logic include this header.
`ifndef UTF16_TO_JSON_UTF8_QUOTER_DEFINES_SVH
`define UTF16_TO_JSON_UTF8_QUOTER_DEFINES_SVH
`ifndef SYNTHESIS
`define UTQT_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);
`define UTQT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define UTQT_ASSERT(lbl, clk, rst_n, prop, msg)
`define UTQT_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== src/utqt_pkg.sv =====
// Shared types, constants and byte-building functions of the quoter.
// No dependencies; used by the front, queue, back and top-level modules.
package utqt_pkg;

	localparam int CMD_FIFO_DEPTH = 2;
	localparam int MAX_BYTES      = 8;
	localparam int CNT_W          = $clog2(MAX_BYTES + 1);
	localparam int IDX_W          = $clog2(MAX_BYTES);
	localparam int BODY_BYTES     = 6;
	localparam int BODY_LEN_W     = $clog2(BODY_BYTES + 1);

	localparam logic [15:0] SURR_HIGH_FIRST = 16'hd800;
	localparam logic [15:0] SURR_HIGH_LAST  = 16'hdbff;
	localparam logic [15:0] SURR_LOW_FIRST  = 16'hdc00;
	localparam logic [15:0] SURR_LOW_LAST   = 16'hdfff;
	localparam logic [15:0] CTRL_LAST       = 16'h001f;
	localparam logic [15:0] ASCII_LAST      = 16'h007f;
	localparam logic [15:0] TWO_BYTE_LAST   = 16'h07ff;
	localparam logic [20:0] SUPP_BASE       = 21'h10000;

	localparam logic [15:0] U_QUOTE  = 16'h0022;
	localparam logic [15:0] U_BSLASH = 16'h005c;
	localparam logic [15:0] U_BS     = 16'h0008;
	localparam logic [15:0] U_FF     = 16'h000c;
	localparam logic [15:0] U_LF     = 16'h000a;
	localparam logic [15:0] U_CR     = 16'h000d;
	localparam logic [15:0] U_TAB    = 16'h0009;

	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5c;
	localparam logic [7:0] CH_LC_B   = 8'h62;
	localparam logic [7:0] CH_LC_F   = 8'h66;
	localparam logic [7:0] CH_LC_N   = 8'h6e;
	localparam logic [7:0] CH_LC_R   = 8'h72;
	localparam logic [7:0] CH_LC_T   = 8'h74;
	localparam logic [7:0] CH_LC_U   = 8'h75;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] HEX_ALPHA_BASE = 8'h57;
	localparam logic [7:0] ERR_BYTE  = 8'h00;

	// One classified item as the back end replays it, byte 0 first.
	typedef struct packed {
		logic [MAX_BYTES-1:0][7:0] bytes;
		logic [CNT_W-1:0]          count;
		logic                      close;
		logic                      err;
	} cmd_t;

	typedef struct packed {
		logic [BODY_BYTES-1:0][7:0] bytes;
		logic [BODY_LEN_W-1:0]      len;
	} body_t;

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		logic [7:0] wide;
		wide = {4'h0, nib};
		return (nib < 4'd10) ? (CH_ZERO + wide) : (HEX_ALPHA_BASE + wide);
	endfunction

	// Escaped or UTF-8 bytes of a unit that is not a surrogate.
	function automatic body_t unit_body(input logic [15:0] u);
		body_t b;
		b = '0;
		case (u)
			U_QUOTE, U_BSLASH: begin
				b.bytes[0] = CH_BSLASH; b.bytes[1] = u[7:0]; b.len = BODY_LEN_W'(2);
			end
			U_BS: begin
				b.bytes[0] = CH_BSLASH; b.bytes[1] = CH_LC_B; b.len = BODY_LEN_W'(2);
			end
			U_FF: begin
				b.bytes[0] = CH_BSLASH; b.bytes[1] = CH_LC_F; b.len = BODY_LEN_W'(2);
			end
			U_LF: begin
				b.bytes[0] = CH_BSLASH; b.bytes[1] = CH_LC_N; b.len = BODY_LEN_W'(2);
			end
			U_CR: begin
				b.bytes[0] = CH_BSLASH; b.bytes[1] = CH_LC_R; b.len = BODY_LEN_W'(2);
			end
			U_TAB: begin
				b.bytes[0] = CH_BSLASH; b.bytes[1] = CH_LC_T; b.len = BODY_LEN_W'(2);
			end
			default: begin
				if (u inside {[16'h0000:CTRL_LAST]}) begin
					b.bytes[0] = CH_BSLASH;
					b.bytes[1] = CH_LC_U;
					b.bytes[2] = CH_ZERO;
					b.bytes[3] = CH_ZERO;
					b.bytes[4] = hex_char(u[7:4]);
					b.bytes[5] = hex_char(u[3:0]);
					b.len      = BODY_LEN_W'(6);
				end else if (u <= ASCII_LAST) begin
					b.bytes[0] = u[7:0];
					b.len      = BODY_LEN_W'(1);
				end else if (u <= TWO_BYTE_LAST) begin
					b.bytes[0] = {3'b110, u[10:6]};
					b.bytes[1] = {2'b10, u[5:0]};
					b.len      = BODY_LEN_W'(2);
				end else begin
					b.bytes[0] = {4'b1110, u[15:12]};
					b.bytes[1] = {2'b10, u[11:6]};
					b.bytes[2] = {2'b10, u[5:0]};
					b.len      = BODY_LEN_W'(3);
				end
			end
		endcase
		return b;
	endfunction

	// Four UTF-8 bytes of a surrogate pair.
	function automatic body_t pair_body(input logic [9:0] hi, input logic [9:0] lo);
		body_t      b;
		logic [20:0] cp;
		b  = '0;
		cp = SUPP_BASE + {1'b0, hi, lo};
		b.bytes[0] = {5'b11110, cp[20:18]};
		b.bytes[1] = {2'b10, cp[17:12]};
		b.bytes[2] = {2'b10, cp[11:6]};
		b.bytes[3] = {2'b10, cp[5:0]};
		b.len      = BODY_LEN_W'(4);
		return b;
	endfunction

endpackage

// ===== src/utf16_to_json_utf8_quoter.sv =====
// Top level of the UTF-16 to quoted JSON UTF-8 encoder.
// Depends on utqt_pkg, utqt_front, utqt_fifo and utqt_back.

// The block takes one UTF-16 code unit per push and delivers the bytes of a
// quoted, escaped JSON string, one byte per pop. The front end accepts a unit
// in every cycle that full is low and classifies it into a command of zero to
// eight bytes; a queue of CMD_DEPTH commands decouples it from the back end,
// which sends one byte per cycle while the output is popped or empty. An item
// thus gives as many output bytes as its command holds: one for plain ASCII,
// up to six for a control escape, plus the quotes at the ends of a string, and
// a held high surrogate or a dropped unit adds no byte of its own. The first
// byte of an item passes the command queue, cur_q and the output register.
// A malformed surrogate yields a single transfer with invalid and last_byte
// set, and the rest of that string is swallowed up to its final unit.
module utf16_to_json_utf8_quoter
	import utqt_pkg::*;
#(
	parameter int CMD_DEPTH = CMD_FIFO_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [15:0] code_unit,
	input  logic        end_of_string,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  out_byte,
	output logic        last_byte,
	output logic        invalid
);

	logic cmd_push;
	logic cmd_full;
	logic cmd_pop;
	logic cmd_empty;
	cmd_t cmd_in;
	cmd_t cmd_out;

	utqt_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.code_unit     (code_unit),
		.end_of_string (end_of_string),
		.cmd_push      (cmd_push),
		.cmd           (cmd_in),
		.cmd_full      (cmd_full)
	);

	utqt_fifo #(
		.DEPTH (CMD_DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cmd_push),
		.wr_data (cmd_in),
		.full    (cmd_full),
		.rd_en   (cmd_pop),
		.rd_data (cmd_out),
		.empty   (cmd_empty)
	);

	utqt_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_empty (cmd_empty),
		.cmd_pop   (cmd_pop),
		.cmd       (cmd_out),
		.out_byte  (out_byte),
		.last_byte (last_byte),
		.invalid   (invalid),
		.empty     (empty),
		.pop       (pop)
	);

endmodule

// ===== src/utqt_front.sv =====
// Front end of the quoter: accepts code units, tracks the string state and
// turns each unit into a byte command. Depends on utqt_pkg and the defines.
`include "utf16_to_json_utf8_quoter_defines.svh"

module utqt_front
	import utqt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [15:0] code_unit,
	input  logic        end_of_string,
	output logic        cmd_push,
	output cmd_t        cmd,
	input  logic        cmd_full
);

	logic       quote_sent_q;
	logic [9:0] held_q;
	logic       pend_q;
	logic       drop_q;

	logic       quote_sent_d;
	logic [9:0] held_d;
	logic       pend_d;
	logic       drop_d;

	logic       accept;
	logic       is_high;
	logic       is_low;
	logic       err;
	logic       opening;
	logic       closing;
	body_t      body;
	logic [MAX_BYTES-1:0][7:0] flat;

	assign full    = cmd_full;
	assign accept  = push && !cmd_full;
	assign is_high = code_unit inside {[SURR_HIGH_FIRST:SURR_HIGH_LAST]};
	assign is_low  = code_unit inside {[SURR_LOW_FIRST:SURR_LOW_LAST]};

	always_comb begin
		quote_sent_d = quote_sent_q;
		held_d       = held_q;
		pend_d       = pend_q;
		drop_d       = drop_q;
		err          = 1'b0;
		opening      = 1'b0;
		closing      = 1'b0;
		body         = '0;
		if (drop_q) begin
			if (end_of_string) begin
				drop_d = 1'b0;
			end
		end else if (pend_q ? !is_low : (is_low || (is_high && end_of_string))) begin
			// A malformed surrogate replaces everything with one error transfer.
			err          = 1'b1;
			quote_sent_d = 1'b0;
			held_d       = '0;
			pend_d       = 1'b0;
			drop_d       = !end_of_string;
		end else begin
			opening      = !quote_sent_q;
			quote_sent_d = 1'b1;
			if (pend_q) begin
				body   = pair_body(held_q, code_unit[9:0]);
				pend_d = 1'b0;
				held_d = '0;
			end else if (is_high) begin
				held_d = code_unit[9:0];
				pend_d = 1'b1;
			end else begin
				body = unit_body(code_unit);
			end
			if (end_of_string) begin
				closing      = 1'b1;
				quote_sent_d = 1'b0;
				held_d       = '0;
				pend_d       = 1'b0;
			end
		end
	end

	always_comb begin
		flat = {{(MAX_BYTES - BODY_BYTES){8'h00}}, body.bytes};
		if (opening) begin
			flat = {flat[MAX_BYTES-2:0], CH_QUOTE};
		end
		cmd.err   = err;
		cmd.close = closing;
		if (err) begin
			cmd.count = CNT_W'(1);
			flat      = '0;
			flat[0]   = ERR_BYTE;
		end else begin
			cmd.count = CNT_W'(opening) + CNT_W'(body.len) + CNT_W'(closing);
		end
		for (int i = 0; i < MAX_BYTES; i++) begin
			if (closing && (CNT_W'(i) == cmd.count - CNT_W'(1))) begin
				flat[i] = CH_QUOTE;
			end
		end
		cmd.bytes = flat;
	end

	assign cmd_push = accept && (cmd.count != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quote_sent_q <= 1'b0;
			held_q       <= '0;
			pend_q       <= 1'b0;
			drop_q       <= 1'b0;
		end else if (accept) begin
			quote_sent_q <= quote_sent_d;
			held_q       <= held_d;
			pend_q       <= pend_d;
			drop_q       <= drop_d;
		end
	end

	`UTQT_ASSERT(a_err_starts_drop, clk, arst_n, (accept && err && !end_of_string) |=> drop_q, "error before end of string did not start dropping")

endmodule

// ===== src/utqt_fifo.sv =====
// Short command queue between the front and back ends of the quoter.
// Depends on utqt_pkg for the command type and on the defines header.
`include "utf16_to_json_utf8_quoter_defines.svh"

module utqt_fifo
	import utqt_pkg::*;
#(
	parameter int DEPTH = CMD_FIFO_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  cmd_t wr_data,
	output logic full,
	input  logic rd_en,
	output cmd_t rd_data,
	output logic empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = $clog2(DEPTH + 1);

	cmd_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	`UTQT_ASSERT(a_count_bound, clk, arst_n, count_q <= CW'(DEPTH), "command queue count exceeds depth")

endmodule

// ===== src/utqt_back.sv =====
// Back end of the quoter: replays queued byte commands into the output register,
// one byte per cycle while it is empty or popped. Depends on utqt_pkg and the defines header.
`include "utf16_to_json_utf8_quoter_defines.svh"

module utqt_back
	import utqt_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_empty,
	output logic       cmd_pop,
	input  cmd_t       cmd,
	output logic [7:0] out_byte,
	output logic       last_byte,
	output logic       invalid,
	output logic       empty,
	input  logic       pop
);

	cmd_t             cur_q;
	logic             cur_valid_q;
	logic [IDX_W-1:0] idx_q;
	logic             out_valid_q;
	logic [7:0]       out_byte_q;
	logic             last_q;
	logic             inv_q;

	logic out_load;
	logic emit;
	logic cur_last;

	assign out_load = !out_valid_q || pop;
	assign emit     = cur_valid_q && out_load;
	assign cur_last = (CNT_W'(idx_q) == cur_q.count - CNT_W'(1));
	assign cmd_pop  = !cmd_empty && (!cur_valid_q || (emit && cur_last));

	assign out_byte  = out_byte_q;
	assign last_byte = last_q;
	assign invalid   = inv_q;
	assign empty     = !out_valid_q;

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cur_q <= cmd;
		end
		if (emit) begin
			out_byte_q <= cur_q.bytes[idx_q];
			last_q     <= (cur_q.close || cur_q.err) && cur_last;
			inv_q      <= cur_q.err;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd_pop) begin
				cur_valid_q <= 1'b1;
				idx_q       <= '0;
			end else if (emit && cur_last) begin
				cur_valid_q <= 1'b0;
			end else if (emit) begin
				idx_q <= idx_q + IDX_W'(1);
			end
			if (out_load) begin
				out_valid_q <= emit;
			end
		end
	end

	`UTQT_ASSERT(a_invalid_is_last, clk, arst_n, (out_valid_q && inv_q) |-> last_q, "error transfer not marked last")
	`UTQT_ASSERT(a_idx_in_range, clk, arst_n, cur_valid_q |-> (CNT_W'(idx_q) < cur_q.count), "byte index beyond command length")

endmodule
